// ===== src/tdei_pkg.sv =====
// ----------------------------------------------------------------------------
// tdei_pkg
// Shared types, event and message codes, phase codes and the phase decoder
// for the two-door entry vestibule sequencer.
// ----------------------------------------------------------------------------
package tdei_pkg;

    // Event codes on the input beat
    localparam logic [3:0] CMD_LS   = 4'd0;
    localparam logic [3:0] CMD_RS   = 4'd1;
    localparam logic [3:0] CMD_WS   = 4'd2;
    localparam logic [3:0] CMD_LO   = 4'd3;
    localparam logic [3:0] CMD_RO   = 4'd4;
    localparam logic [3:0] CMD_LC   = 4'd5;
    localparam logic [3:0] CMD_RC   = 4'd6;
    localparam logic [3:0] CMD_GRU  = 4'd7;
    localparam logic [3:0] CMD_GRL  = 4'd8;
    localparam logic [3:0] CMD_GLU  = 4'd9;
    localparam logic [3:0] CMD_GLL  = 4'd10;
    localparam logic [3:0] CMD_EXIT = 4'd11;

    // Display message codes on the result beat
    localparam logic [3:0] MSG_SCAN = 4'd0;
    localparam logic [3:0] MSG_GLU  = 4'd1;
    localparam logic [3:0] MSG_GRU  = 4'd2;
    localparam logic [3:0] MSG_LO   = 4'd3;
    localparam logic [3:0] MSG_RO   = 4'd4;
    localparam logic [3:0] MSG_WS   = 4'd5;
    localparam logic [3:0] MSG_LC   = 4'd6;
    localparam logic [3:0] MSG_RC   = 4'd7;
    localparam logic [3:0] MSG_GLL  = 4'd8;
    localparam logic [3:0] MSG_GRL  = 4'd9;
    localparam logic [3:0] MSG_EXIT = 4'd10;

    // Phase codes
    localparam logic [3:0] PH_SCAN    = 4'd0;
    localparam logic [3:0] PH_UNLOCK1 = 4'd1;
    localparam logic [3:0] PH_OPEN1   = 4'd2;
    localparam logic [3:0] PH_WEIGH   = 4'd3;
    localparam logic [3:0] PH_CLOSE1  = 4'd4;
    localparam logic [3:0] PH_LOCK1   = 4'd5;
    localparam logic [3:0] PH_UNLOCK2 = 4'd6;
    localparam logic [3:0] PH_OPEN2   = 4'd7;
    localparam logic [3:0] PH_CLOSE2  = 4'd8;
    localparam logic [3:0] PH_LOCK2   = 4'd9;

    // Entry side codes
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Last shown person after reset or a completed cycle
    localparam logic signed [31:0] LAST_ID_INIT     = -32'sd99;
    localparam logic signed [15:0] LAST_WEIGHT_INIT = -16'sd1;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] person_id;
        logic signed [15:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         message_code;
        logic signed [31:0] shown_person_id;
        logic signed [15:0] shown_weight;
    } out_item_t;

    // Expected event and message for one phase of the walk
    typedef struct packed {
        logic       ok;
        logic [3:0] want;
        logic [3:0] code;
    } rule_t;

    function automatic rule_t phase_rule(input logic [3:0] phase, input logic [1:0] side);
        rule_t r;
        logic  lft;
        r   = '0;
        lft = (side == SIDE_LEFT);
        r.ok = (side == SIDE_LEFT) || (side == SIDE_RIGHT);
        unique case (phase)
            PH_UNLOCK1: begin
                r.want = lft ? CMD_GLU : CMD_GRU;
                r.code = lft ? MSG_GLU : MSG_GRU;
            end
            PH_OPEN1: begin
                r.want = lft ? CMD_LO : CMD_RO;
                r.code = lft ? MSG_LO : MSG_RO;
            end
            PH_WEIGH: begin
                r.want = CMD_WS;
                r.code = MSG_WS;
            end
            PH_CLOSE1: begin
                r.want = lft ? CMD_LC : CMD_RC;
                r.code = lft ? MSG_LC : MSG_RC;
            end
            PH_LOCK1: begin
                r.want = lft ? CMD_GLL : CMD_GRL;
                r.code = lft ? MSG_GLL : MSG_GRL;
            end
            PH_UNLOCK2: begin
                r.want = lft ? CMD_GRU : CMD_GLU;
                r.code = lft ? MSG_GRU : MSG_GLU;
            end
            PH_OPEN2: begin
                r.want = lft ? CMD_RO : CMD_LO;
                r.code = lft ? MSG_RO : MSG_LO;
            end
            PH_CLOSE2: begin
                r.want = lft ? CMD_RC : CMD_LC;
                r.code = lft ? MSG_RC : MSG_LC;
            end
            PH_LOCK2: begin
                r.want = lft ? CMD_GRL : CMD_GLL;
                r.code = lft ? MSG_GRL : MSG_GLL;
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/tdei_in_stage.sv =====
// ----------------------------------------------------------------------------
// tdei_in_stage
// Input register: captures one event beat and holds it until the sequencer
// takes it.
// ----------------------------------------------------------------------------
module tdei_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tdei_pkg::in_item_t s_data,
    output logic               item_valid,
    input  logic               item_ready,
    output tdei_pkg::in_item_t item
);

    logic               valid_reg;
    tdei_pkg::in_item_t data_reg;

    // Refill when empty or when the held beat leaves this cycle
    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== src/tdei_seq.sv =====
// ----------------------------------------------------------------------------
// tdei_seq
// Phase sequencer: holds phase, side, halt flag and last shown person, and
// decides for each event whether it advances and what it displays.
// ----------------------------------------------------------------------------
module tdei_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  tdei_pkg::in_item_t  item,
    output logic                res_valid,
    input  logic                res_ready,
    output tdei_pkg::out_item_t res
);

    logic [3:0]         phase_reg,  phase_next;
    logic [1:0]         side_reg,   side_next;
    logic               halted_reg, halted_next;
    logic signed [31:0] last_id_reg, last_id_next;
    logic signed [15:0] last_wt_reg, last_wt_next;

    tdei_pkg::rule_t rule;
    logic            emit;
    logic            step;

    assign item_ready = res_ready;
    assign step       = item_valid && res_ready;
    assign rule       = tdei_pkg::phase_rule(phase_reg, side_reg);

    always_comb begin
        emit         = 1'b0;
        res          = '0;
        phase_next   = phase_reg;
        side_next    = side_reg;
        halted_next  = halted_reg;
        last_id_next = last_id_reg;
        last_wt_next = last_wt_reg;
        if (halted_reg) begin
            emit = 1'b0;
        end else if (item.command == tdei_pkg::CMD_EXIT) begin
            emit                = 1'b1;
            res.message_code    = tdei_pkg::MSG_EXIT;
            res.shown_person_id = last_id_reg;
            res.shown_weight    = last_wt_reg;
            halted_next         = 1'b1;
        end else if (phase_reg == tdei_pkg::PH_SCAN) begin
            if (item.command == tdei_pkg::CMD_LS || item.command == tdei_pkg::CMD_RS) begin
                emit                = 1'b1;
                res.message_code    = tdei_pkg::MSG_SCAN;
                res.shown_person_id = item.person_id;
                res.shown_weight    = item.weight;
                side_next           = (item.command == tdei_pkg::CMD_RS) ?
                                      tdei_pkg::SIDE_RIGHT : tdei_pkg::SIDE_LEFT;
                phase_next          = tdei_pkg::PH_UNLOCK1;
                last_id_next        = item.person_id;
                last_wt_next        = item.weight;
            end
        end else if (rule.ok && item.command == rule.want) begin
            emit                = 1'b1;
            res.message_code    = rule.code;
            res.shown_person_id = item.person_id;
            res.shown_weight    = item.weight;
            if (phase_reg == tdei_pkg::PH_LOCK2) begin
                phase_next   = tdei_pkg::PH_SCAN;
                side_next    = tdei_pkg::SIDE_NONE;
                last_id_next = tdei_pkg::LAST_ID_INIT;
                last_wt_next = tdei_pkg::LAST_WEIGHT_INIT;
            end else begin
                phase_next   = phase_reg + 4'd1;
                last_id_next = item.person_id;
                last_wt_next = item.weight;
            end
        end
    end

    assign res_valid = item_valid && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tdei_pkg::PH_SCAN;
            side_reg    <= tdei_pkg::SIDE_NONE;
            halted_reg  <= 1'b0;
            last_id_reg <= tdei_pkg::LAST_ID_INIT;
            last_wt_reg <= tdei_pkg::LAST_WEIGHT_INIT;
        end else if (step) begin
            phase_reg   <= phase_next;
            side_reg    <= side_next;
            halted_reg  <= halted_next;
            last_id_reg <= last_id_next;
            last_wt_reg <= last_wt_next;
        end
    end

`ifndef ASSERT_OFF
    // Halt holds until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped without reset");

    // A halted sequencer displays nothing
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !res_valid)
        else $error("result produced while halted");

    // Past door scan a side is always chosen
    a_side_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != tdei_pkg::PH_SCAN) |->
            (side_reg == tdei_pkg::SIDE_LEFT || side_reg == tdei_pkg::SIDE_RIGHT))
        else $error("phase advanced without an entry side");

    // Phase never leaves the walk
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= tdei_pkg::PH_LOCK2)
        else $error("phase out of range");
`endif

endmodule

// ===== src/tdei_out_stage.sv =====
// ----------------------------------------------------------------------------
// tdei_out_stage
// Result register: holds one display message beat until the consumer takes
// it; the sequencer stalls while the register is full and not taken.
// ----------------------------------------------------------------------------
module tdei_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    output logic                res_ready,
    input  tdei_pkg::out_item_t res,
    output logic                m_valid,
    input  logic                m_ready,
    output tdei_pkg::out_item_t m_data
);

    logic                valid_reg;
    tdei_pkg::out_item_t data_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_data    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

endmodule

// ===== src/two_door_entry_interlock_fsm.sv =====
// Path: an event beat passes the input register, then its message beat the result register, to m_.
// Throughput: one event beat per cycle while the result register has room; the phase decode
// sits between the input register and the result register, so nothing iterates.
// Reset: aresetn low at a clock edge empties both registers, returns to door scan
// with no side chosen, clears the halt flag and sets the last shown person to -99 / -1.
// ----------------------------------------------------------------------------
// two_door_entry_interlock_fsm
// Sequencer for a two-door entry vestibule. A left or right card scan picks
// the entry side; the guard unlock, open, weight scan, close and guard lock
// events of both doors then have to arrive in order, mirrored by side. Each
// expected event shows a display message with its person fields; EXIT shows
// the last displayed person of an unfinished walk, else -99 / -1, and halts until reset.
// ----------------------------------------------------------------------------
module two_door_entry_interlock_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    // Event beats
    input  logic                s_valid,
    output logic                s_ready,
    input  tdei_pkg::in_item_t  s_data,
    // Display message beats
    output logic                m_valid,
    input  logic                m_ready,
    output tdei_pkg::out_item_t m_data
);

    // Event held in the input register
    logic                item_valid;
    logic                item_ready;
    tdei_pkg::in_item_t  item;

    // Message decided this cycle, headed for the result register
    logic                res_valid;
    logic                res_ready;
    tdei_pkg::out_item_t res;

    // Capture the event beat; advance it whenever the result side has room
    tdei_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Decode the event against the current phase; ignored events drop here
    // without a message, but still leave the input register
    tdei_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Hold the message beat until the consumer takes it
    tdei_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
